// File: hw/rtl/snap_exponential_smoother_top_assert.svh
// Assertion macros used by the smoother checker.
`ifndef SNAP_EXPONENTIAL_SMOOTHER_TOP_ASSERT_SVH
`define SNAP_EXPONENTIAL_SMOOTHER_TOP_ASSERT_SVH

// Check a property while the block is out of reset.
`define SES_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a property at every edge, reset included.
`define SES_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/ses_pkg.sv
// Widths, field positions and register defaults of the exponential smoother.
package ses_pkg;

    localparam int ANGLE_W   = 17;
    localparam int MS_W      = 16;
    localparam int THR_W     = 17;
    localparam int ALPHA_W   = 17;
    localparam int LANES     = 3;

    // Input item layout, lowest bit first: raw_angle_a, raw_angle_b, raw_angle_c, elapsed_ms
    localparam int S_MS_LSB      = LANES * ANGLE_W;
    localparam int S_FIELDS_W    = S_MS_LSB + MS_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    // Result item layout, lowest bit first: smooth_angle_a, smooth_angle_b, smooth_angle_c
    localparam int M_FIELDS_W    = LANES * ANGLE_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2000);

    // Saturation point of the elapsed time before the gain lookup
    localparam int ALPHA_ENTRIES = 256;
    localparam int ALPHA_IDX_W   = 8;

    typedef logic [ALPHA_W-1:0] alpha_tab_t [ALPHA_ENTRIES];

endpackage

// File: hw/rtl/snap_exponential_smoother_top.sv
// Three-lane exponential smoother with snap, stream in and stream out.
//
// Usage:
//   s_* channel takes one item per handshake: three raw angles in hundredths
//   of a degree and the elapsed time in ms since the previous item.
//   m_* channel gives one item per input item: the three smoothed angles.
//   cfg_wr_en/cfg_wr_data write the snap threshold; write it while idle.
// Path: an accepted item is held in the input register, then registered into
//   the smoothed angle registers, which drive m_*.
// Throughput: one item per cycle while m_tready is high; the loop closing
//   through the smoothed angle registers (subtract, 17x18 multiply, add) is combinational.
// Reset (aresetn low, synchronous): both stages empty, smoothed angles
//   cleared, threshold back to 2000; the first item after reset copies the
//   raw angles.
// Stall: while m_tready is low the result holds; one more item is taken
//   into the input register, then s_tready drops until the result leaves.
// The gain table is built at elaboration from TAU_MS.
module snap_exponential_smoother_top #(
    parameter int unsigned TAU_MS = 100
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ses_pkg::THR_W-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // raw_angle_a, raw_angle_b, raw_angle_c, elapsed_ms, zero pad
    input  logic [ses_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // smooth_angle_a, smooth_angle_b, smooth_angle_c, zero pad
    output logic [ses_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW = ses_pkg::ANGLE_W;
    localparam int NL = ses_pkg::LANES;
    localparam int PROD_W = 2 * (AW + 1);
    localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
    localparam logic [63:0] TAU_EFF = (TAU_MS < 1) ? 64'd1 : 64'(TAU_MS);

    // Restoring long division, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Integer build of round(65536 * (1 - exp(-k / TAU_MS))) from a Q62 Taylor sum and its powers.
    function automatic ses_pkg::alpha_tab_t build_alpha_tab();
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  p;
        logic [63:0]  d;
        logic [127:0] prod;
        ses_pkg::alpha_tab_t tab;
        term = ONE_Q62;
        sum  = ONE_Q62;
        p    = ONE_Q62;
        for (int n = 1; n < 64; n++) begin
            term = udiv64(term, TAU_EFF * 64'(n));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int k = 0; k < ses_pkg::ALPHA_ENTRIES; k++) begin
            d      = ONE_Q62 - p;
            tab[k] = ses_pkg::ALPHA_W'((d + (64'd1 << 45)) >> 46);
            prod   = 128'(p) * 128'(sum);
            p      = 64'(prod >> 62) + 64'(prod[61]);
        end
        return tab;
    endfunction

    localparam ses_pkg::alpha_tab_t ALPHA_TAB = build_alpha_tab();

    logic [ses_pkg::THR_W-1:0]    thr_reg;
    logic                         in_valid_reg;
    logic [AW-1:0]                raw_reg [NL];
    logic [ses_pkg::ALPHA_W-1:0]  alpha_reg;
    logic                         out_valid_reg;
    logic                         primed_reg;
    logic [AW-1:0]                smooth_reg [NL];
    logic [AW-1:0]                smooth_next [NL];

    logic                             s_fire;
    logic                             advance;
    logic [ses_pkg::ALPHA_IDX_W-1:0]  alpha_idx;
    logic [ses_pkg::MS_W-1:0]         ms_in;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign ms_in     = s_tdata[ses_pkg::S_MS_LSB +: ses_pkg::MS_W];
    assign alpha_idx = (ms_in > ses_pkg::MS_W'(ses_pkg::ALPHA_ENTRIES - 1))
                     ? ses_pkg::ALPHA_IDX_W'(ses_pkg::ALPHA_ENTRIES - 1)
                     : ms_in[ses_pkg::ALPHA_IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= ses_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Input stage: hold raw angles and the looked-up gain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < NL; i++) begin
                raw_reg[i] <= s_tdata[i*AW +: AW];
            end
            alpha_reg <= ALPHA_TAB[alpha_idx];
        end
    end

    // Per lane: snap on the first item after reset or a large step, else move by (alpha * diff) >>> 16.
    for (genvar g = 0; g < NL; g++) begin : g_lane
        logic signed [AW:0]       diff;
        logic        [AW:0]       mag;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] step;

        always_comb begin
            diff = $signed({raw_reg[g][AW-1], raw_reg[g]})
                 - $signed({smooth_reg[g][AW-1], smooth_reg[g]});
            mag  = diff[AW] ? (AW+1)'(-diff) : diff;
            prod = PROD_W'($signed({1'b0, alpha_reg})) * PROD_W'(diff);
            step = prod >>> 16;
            if (!primed_reg || (mag > {1'b0, thr_reg})) begin
                smooth_next[g] = raw_reg[g];
            end else begin
                smooth_next[g] = AW'(smooth_reg[g] + step[AW-1:0]);
            end
        end
    end

    // Result stage: the smoothed angles double as the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            for (int i = 0; i < NL; i++) begin
                smooth_reg[i] <= '0;
            end
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                primed_reg    <= 1'b1;
                for (int i = 0; i < NL; i++) begin
                    smooth_reg[i] <= smooth_next[i];
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < NL; i++) begin
            m_tdata[i*AW +: AW] = smooth_reg[i];
        end
    end

endmodule

// File: hw/rtl/ses_checker.sv
// Port-level checker for the exponential smoother, bound to the top level.
`include "snap_exponential_smoother_top_assert.svh"

module ses_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ses_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds.
    `SES_ASSERT(a_stall_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // Reset empties both stages.
    `SES_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_tvalid && s_tready))

    // With no result waiting, an item can always enter.
    `SES_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)

    // Pad bits above the three angles stay zero.
    `SES_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[ses_pkg::M_TDATA_W-1:ses_pkg::M_FIELDS_W] == '0))

endmodule

bind snap_exponential_smoother_top ses_checker u_ses_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/snap_exponential_smoother_top_tb.sv
// Self-checking testbench for the three-lane exponential smoother with snap.
`timescale 1ns / 1ps

module snap_exponential_smoother_top_tb;

    localparam int unsigned TAU_MS = 100;
    localparam int ANGLE_SPAN = 36000;
    localparam logic [ses_pkg::THR_W-1:0] THR_TOP = ses_pkg::THR_W'(72000);
    localparam int ITEMS_PER_PHASE = 172;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;

    // Packed so that lane a sits in the lowest bits, as on the bus.
    typedef struct packed {
        logic [ses_pkg::MS_W-1:0]           ms;
        logic signed [ses_pkg::ANGLE_W-1:0] c;
        logic signed [ses_pkg::ANGLE_W-1:0] b;
        logic signed [ses_pkg::ANGLE_W-1:0] a;
    } raw_item_t;

    typedef struct packed {
        logic signed [ses_pkg::ANGLE_W-1:0] c;
        logic signed [ses_pkg::ANGLE_W-1:0] b;
        logic signed [ses_pkg::ANGLE_W-1:0] a;
    } smooth_t;

    typedef struct packed {
        logic    known;
        smooth_t val;
    } pin_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [ses_pkg::THR_W-1:0] thr;
        raw_item_t                 item;
        logic                      pinned;
        smooth_t                   want;
    } row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    localparam int N_DIRECTED = 20;
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // first item after reset copies the raw angles
        '{kind: ROW_ITEM, thr: '0, item: '{a: 36000, b: -36000, c: 0, ms: 0},
          pinned: 1'b1, want: '{a: 36000, b: -36000, c: 0}},
        // zero gain holds small moves, lane c snaps
        '{kind: ROW_ITEM, thr: '0, item: '{a: 36100, b: -36100, c: 5000, ms: 0},
          pinned: 1'b1, want: '{a: 36000, b: -36000, c: 5000}},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 36100, b: -36100, c: 5000, ms: 65535},
          pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 36100, b: -36100, c: 5000, ms: 255},
          pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 36500, b: -35000, c: 3000, ms: 256},
          pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 35000, b: -34000, c: 1000, ms: 1},
          pinned: 1'b0, want: '0},
        // outside the angle range, far away: every lane snaps
        '{kind: ROW_ITEM, thr: '0, item: '{a: 65535, b: -65536, c: -20000, ms: 50},
          pinned: 1'b1, want: '{a: 65535, b: -65536, c: -20000}},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 65535, b: -65536, c: -20000, ms: 0},
          pinned: 1'b1, want: '{a: 65535, b: -65536, c: -20000}},
        // difference exactly at the threshold smooths instead of snapping
        '{kind: ROW_ITEM, thr: '0, item: '{a: 63535, b: -63536, c: -18000, ms: 65535},
          pinned: 1'b0, want: '0},
        '{kind: ROW_CFG, thr: '0, item: '0, pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 0, b: 1, c: -1, ms: 100},
          pinned: 1'b1, want: '{a: 0, b: 1, c: -1}},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 0, b: 1, c: -1, ms: 100},
          pinned: 1'b1, want: '{a: 0, b: 1, c: -1}},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 1, b: 0, c: -2, ms: 255},
          pinned: 1'b1, want: '{a: 1, b: 0, c: -2}},
        '{kind: ROW_CFG, thr: THR_TOP, item: '0, pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 36000, b: -36000, c: 36000, ms: 255},
          pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: -36000, b: 36000, c: -36000, ms: 65535},
          pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: 65535, b: -65536, c: 0, ms: 10},
          pinned: 1'b0, want: '0},
        '{kind: ROW_CFG, thr: 17'h1FFFF, item: '0, pinned: 1'b0, want: '0},
        '{kind: ROW_ITEM, thr: '0, item: '{a: -65536, b: 65535, c: 65535, ms: 255},
          pinned: 1'b0, want: '0},
        '{kind: ROW_CFG, thr: ses_pkg::THR_RESET, item: '0, pinned: 1'b0, want: '0}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [ses_pkg::THR_W-1:0]     cfg_wr_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ses_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ses_pkg::M_TDATA_W-1:0] m_tdata;

    // Smoother copy: gain table, held angles, primed flag, threshold.
    int unsigned                        gain_tab [ses_pkg::ALPHA_ENTRIES];
    logic signed [ses_pkg::ANGLE_W-1:0] held_angle [ses_pkg::LANES];
    logic                               tracking = 1'b0;
    logic [ses_pkg::THR_W-1:0]          snap_limit = ses_pkg::THR_RESET;

    smooth_t     smooth_q [$];
    pin_t        pinned_q [$];
    int unsigned sent_cnt = 0;
    int unsigned rcvd_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    int          burst_left = 0;
    logic        hold_req = 1'b0;

    snap_exponential_smoother_top #(
        .TAU_MS(TAU_MS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Gain table: exp(-1/tau) as a Q62 Taylor sum, powers by rounded Q62 products.
    initial begin
        longint unsigned one_q62, tau, term, sum, p, d;
        logic [127:0] prod;
        one_q62 = 64'd1 << 62;
        tau = (TAU_MS < 1) ? 64'd1 : 64'(TAU_MS);
        term = one_q62;
        sum = one_q62;
        p = one_q62;
        for (longint unsigned n = 1; n < 64 && term != 0; n++) begin
            term = term / (tau * n);
            if (n[0])
                sum -= term;
            else
                sum += term;
        end
        for (int k = 0; k < ses_pkg::ALPHA_ENTRIES; k++) begin
            d = one_q62 - p;
            gain_tab[k] = 32'((d + (64'd1 << 45)) >> 46);
            prod = 128'(p) * 128'(sum);
            p = 64'((prod + (128'd1 << 61)) >> 62);
        end
        for (int i = 0; i < ses_pkg::LANES; i++)
            held_angle[i] = '0;
    end

    function automatic smooth_t smooth_step(input raw_item_t it);
        logic signed [ses_pkg::ANGLE_W-1:0] raw [ses_pkg::LANES];
        int unsigned gain;
        int idx;
        longint diff, mag;
        smooth_t r;
        raw[0] = it.a;
        raw[1] = it.b;
        raw[2] = it.c;
        idx = int'(it.ms);
        if (idx > ses_pkg::ALPHA_ENTRIES - 1)
            idx = ses_pkg::ALPHA_ENTRIES - 1;
        gain = gain_tab[idx];
        for (int i = 0; i < ses_pkg::LANES; i++) begin
            if (!tracking) begin
                held_angle[i] = raw[i];
            end else begin
                diff = longint'(raw[i]) - longint'(held_angle[i]);
                mag = (diff < 0) ? -diff : diff;
                if (mag > longint'(snap_limit))
                    held_angle[i] = raw[i];
                else
                    held_angle[i] = held_angle[i]
                                  + ses_pkg::ANGLE_W'((longint'(gain) * diff) >>> 16);
            end
        end
        tracking = 1'b1;
        r.a = held_angle[0];
        r.b = held_angle[1];
        r.c = held_angle[2];
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s", msg);
    endtask

    // Predict on every accepted item; a pinned row overrides the prediction.
    always @(posedge aclk) begin
        smooth_t want;
        pin_t pin;
        if (aresetn && s_tvalid && s_tready) begin
            want = smooth_step(raw_item_t'(s_tdata[ses_pkg::S_FIELDS_W-1:0]));
            pin = pinned_q.pop_front();
            if (pin.known)
                want = pin.val;
            smooth_q.push_back(want);
        end
    end

    always @(posedge aclk) begin
        smooth_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = smooth_t'(m_tdata[ses_pkg::M_FIELDS_W-1:0]);
            rcvd_cnt++;
            if (smooth_q.size() == 0) begin
                note_error($sformatf("unexpected result a=%0d b=%0d c=%0d",
                                     got.a, got.b, got.c));
            end else begin
                want = smooth_q.pop_front();
                if (got.a !== want.a || got.b !== want.b || got.c !== want.c)
                    note_error($sformatf(
                        "mismatch at result %0d: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                        rcvd_cnt, want.a, want.b, want.c, got.a, got.b, got.c));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: rotate through stall patterns; hold off for a long stretch on request.
    initial begin
        int unsigned cyc;
        rx_mode_t mode;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode = rx_mode_t'((cyc / 97) % 4);
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Offer one item, with a random gap when the current burst is used up.
    task automatic offer(input raw_item_t it, input logic pin, input smooth_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        pinned_q.push_back('{known: pin, val: want});
        s_tvalid <= 1'b1;
        s_tdata <= ses_pkg::S_TDATA_W'(it);
        do @(posedge aclk); while (!s_tready);
        sent_cnt++;
    endtask

    // Drain the pipeline: drop s_tvalid and wait until every result is in.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (rcvd_cnt != sent_cnt) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_thr(input logic [ses_pkg::THR_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        snap_limit = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        int base [ses_pkg::LANES];
        int v, lim, pick;
        raw_item_t it;
        logic [ses_pkg::THR_W-1:0] thr_v;
        for (int i = 0; i < ses_pkg::LANES; i++)
            base[i] = 0;
        do @(posedge aclk); while (!aresetn);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                settle();
                write_thr(DIRECTED[r].thr);
            end else begin
                offer(DIRECTED[r].item, DIRECTED[r].pinned, DIRECTED[r].want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                settle();
                case (ph)
                    1:       thr_v = '0;
                    2:       thr_v = THR_TOP;
                    3:       thr_v = ses_pkg::THR_W'($urandom_range(0, THR_TOP));
                    4:       thr_v = ses_pkg::THR_W'($urandom);
                    default: thr_v = ses_pkg::THR_W'($urandom_range(1, 400));
                endcase
                write_thr(thr_v);
            end
            // back-to-back items against a long receiver stall
            if (ph == 2) begin
                hold_req = 1'b1;
                burst_left = 60;
            end
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                lim = int'(snap_limit) * 5 / 4 + 3;
                if (lim > 40000)
                    lim = 40000;
                for (int i = 0; i < ses_pkg::LANES; i++) begin
                    if (pick < 70) begin
                        // track a wandering target, steps around the threshold
                        v = base[i] + int'($urandom_range(0, 2 * lim)) - lim;
                        if (v > 65535)
                            v = 65535;
                        if (v < -65536)
                            v = -65536;
                    end else if (pick < 85) begin
                        v = int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
                    end else begin
                        v = int'($urandom_range(0, 131071)) - 65536;
                    end
                    base[i] = v;
                end
                it.a = ses_pkg::ANGLE_W'(base[0]);
                it.b = ses_pkg::ANGLE_W'(base[1]);
                it.c = ses_pkg::ANGLE_W'(base[2]);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    it.ms = ses_pkg::MS_W'($urandom_range(0, 255));
                else if (pick < 8)
                    it.ms = ses_pkg::MS_W'($urandom_range(0, 20));
                else
                    it.ms = ses_pkg::MS_W'($urandom_range(0, 65535));
                offer(it, 1'b0, '0);
            end
        end

        settle();
        if (smooth_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", smooth_q.size()));
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
